### design/hkrb_pkg.sv
// hkrb_pkg: shared types and constants for the hid keyboard report builder
// depends on nothing; imported by the core module and the bench
package hkrb_pkg;

    // number of key slots kept in the report (range 1 to 16)
    localparam int KEY_SLOTS   = 6;
    // key fields shown on the result ports
    localparam int SHOWN_SLOTS = 6;

    // modifier usage range, 0xe0 up to 0xe7
    localparam logic [7:0] MOD_FIRST = 8'hE0;
    localparam logic [7:0] MOD_LAST  = 8'hE7;
    localparam logic [7:0] NO_KEY    = 8'h00;

    typedef enum logic [1:0] {
        ACT_PRESS       = 2'd0,
        ACT_RELEASE     = 2'd1,
        ACT_RELEASE_ALL = 2'd2,
        ACT_HOST_LED    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_NOLINK  = 2'd3
    } status_t;

endpackage

### design/hid_keyboard_report_builder_core.sv
// hid_keyboard_report_builder_core: boot keyboard report keeper, six-key rollover
// depends on hkrb_pkg for slot count, modifier range, action and status codes
//
// a result strobes on done once the item taken with start has passed the item and result registers
// throughput: one item every cycle; busy stays low, the item register feeds one
//   pass of slot compares and priority picks into the state and result registers
// reset: rst_n clears modifiers, all key slots, the led byte and both valid flags
// the receiver cannot stall: each result is strobed on done for one cycle only
module hid_keyboard_report_builder_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  hkrb_pkg::action_t    action,
    input  logic [7:0]           keycode,
    input  logic                 link_up,
    input  logic [7:0]           led_byte,
    input  logic                 report_match,
    output logic                 done,
    output hkrb_pkg::status_t    status,
    output logic                 report_sent,
    output logic [7:0]           modifiers,
    output logic [7:0]           key_a,
    output logic [7:0]           key_b,
    output logic [7:0]           key_c,
    output logic [7:0]           key_d,
    output logic [7:0]           key_e,
    output logic [7:0]           key_f,
    output logic [7:0]           led_state
);
    import hkrb_pkg::*;

    // item register
    logic        in_valid_reg;
    action_t     act_reg;
    logic [7:0]  code_reg;
    logic        link_reg;
    logic [7:0]  led_reg;
    logic        match_reg;

    // report state
    logic [7:0]  mod_reg;
    logic [7:0]  mod_next;
    logic [7:0]  held_reg  [KEY_SLOTS];
    logic [7:0]  held_next [KEY_SLOTS];
    logic [7:0]  leds_reg;
    logic [7:0]  leds_next;

    // result register (the report fields come straight from the state)
    logic        done_reg;
    status_t     status_reg;
    status_t     status_next;
    logic        sent_reg;
    logic        sent_next;

    // slot compare results
    logic [KEY_SLOTS-1:0] hit_vec;
    logic [KEY_SLOTS-1:0] free_vec;
    logic [KEY_SLOTS-1:0] first_hit;
    logic [KEY_SLOTS-1:0] first_free;
    logic                 is_mod;
    logic [7:0]           mod_bit;
    logic                 slots_full;

    // every item is worked in one pass, so the block never holds off start
    assign busy = 1'b0;

    // capture the item
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk) begin
        if (start && !busy) begin
            act_reg   <= action;
            code_reg  <= keycode;
            link_reg  <= link_up;
            led_reg   <= led_byte;
            match_reg <= report_match;
        end
    end

    // parallel slot compares, then a priority pick of the lowest hit and free slot
    always_comb begin
        logic seen_hit;
        logic seen_free;
        seen_hit   = 1'b0;
        seen_free  = 1'b0;
        first_hit  = '0;
        first_free = '0;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            hit_vec[i]  = (held_reg[i] == code_reg);
            free_vec[i] = (held_reg[i] == NO_KEY);
            if (hit_vec[i] && !seen_hit) begin
                first_hit[i] = 1'b1;
            end
            if (free_vec[i] && !seen_free) begin
                first_free[i] = 1'b1;
            end
            seen_hit  = seen_hit || hit_vec[i];
            seen_free = seen_free || free_vec[i];
        end
    end

    assign slots_full = ~|free_vec;
    assign is_mod     = (code_reg >= MOD_FIRST) && (code_reg <= MOD_LAST);
    // bit n of the modifier map is usage 0xe0 plus n
    assign mod_bit    = 8'(1) << code_reg[2:0];

    // one pass of the action over the state
    always_comb begin
        mod_next    = mod_reg;
        leds_next   = leds_reg;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            held_next[i] = held_reg[i];
        end
        status_next = ST_OK;
        sent_next   = 1'b0;

        unique case (act_reg)
            ACT_PRESS: begin
                if (code_reg == NO_KEY) begin
                    status_next = ST_INVALID;
                end
                else if (is_mod) begin
                    mod_next    = mod_reg | mod_bit;
                    status_next = link_reg ? ST_OK : ST_NOLINK;
                    sent_next   = link_reg;
                end
                else if (|hit_vec) begin
                    // already held: nothing changes, nothing goes out
                    status_next = ST_OK;
                end
                else if (slots_full) begin
                    status_next = ST_FULL;
                end
                else begin
                    for (int i = 0; i < KEY_SLOTS; i++) begin
                        if (first_free[i]) begin
                            held_next[i] = code_reg;
                        end
                    end
                    status_next = link_reg ? ST_OK : ST_NOLINK;
                    sent_next   = link_reg;
                end
            end
            ACT_RELEASE: begin
                if (code_reg == NO_KEY) begin
                    status_next = ST_INVALID;
                end
                else begin
                    if (is_mod) begin
                        mod_next = mod_reg & ~mod_bit;
                    end
                    else begin
                        // a key that is not held still sends a report
                        for (int i = 0; i < KEY_SLOTS; i++) begin
                            if (first_hit[i]) begin
                                held_next[i] = NO_KEY;
                            end
                        end
                    end
                    status_next = link_reg ? ST_OK : ST_NOLINK;
                    sent_next   = link_reg;
                end
            end
            ACT_RELEASE_ALL: begin
                mod_next = '0;
                for (int i = 0; i < KEY_SLOTS; i++) begin
                    held_next[i] = NO_KEY;
                end
                status_next = link_reg ? ST_OK : ST_NOLINK;
                sent_next   = link_reg;
            end
            ACT_HOST_LED: begin
                if (match_reg) begin
                    leds_next = led_reg;
                end
            end
            default: begin
                status_next = ST_OK;
            end
        endcase
    end

    // state and result registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mod_reg  <= '0;
            leds_reg <= '0;
            for (int i = 0; i < KEY_SLOTS; i++) begin
                held_reg[i] <= NO_KEY;
            end
            done_reg <= 1'b0;
        end
        else begin
            done_reg <= in_valid_reg;
            if (in_valid_reg) begin
                mod_reg  <= mod_next;
                leds_reg <= leds_next;
                for (int i = 0; i < KEY_SLOTS; i++) begin
                    held_reg[i] <= held_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (in_valid_reg) begin
            status_reg <= status_next;
            sent_reg   <= sent_next;
        end
    end

    // shown key fields; slots past the configured count read as empty
    logic [7:0] shown [SHOWN_SLOTS];

    generate
        for (genvar g = 0; g < SHOWN_SLOTS; g++) begin : g_shown
            if (g < KEY_SLOTS) begin : g_slot
                assign shown[g] = held_reg[g];
            end
            else begin : g_none
                assign shown[g] = NO_KEY;
            end
        end
    endgenerate

    assign done        = done_reg;
    assign status      = status_reg;
    assign report_sent = sent_reg;
    assign modifiers   = mod_reg;
    assign key_a       = shown[0];
    assign key_b       = shown[1];
    assign key_c       = shown[2];
    assign key_d       = shown[3];
    assign key_e       = shown[4];
    assign key_f       = shown[5];
    assign led_state   = leds_reg;

    // a sent report always carries an ok status
    a_sent_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && report_sent |-> status == ST_OK)
        else $error("report sent with a non-ok status");

    // slots full is only reported when no slot is empty
    a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_FULL |-> slots_full)
        else $error("slots full reported with an empty slot");

    // an invalid keycode leaves the report untouched
    a_invalid_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_INVALID |-> $stable(mod_reg) && $stable(key_a)
            && $stable(leds_reg))
        else $error("invalid keycode changed the report");

    // every result follows an item taken with start, through the item and result registers
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 2))
        else $error("result without an item two cycles before");

endmodule

### tb/tb.sv
// tb: self-checking bench for hid_keyboard_report_builder_core, key events in, reports out
// depends on hkrb_pkg (slot count, modifier range, action and status codes) and the core
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hkrb_pkg::*;

    localparam int CYCLE_LIMIT   = 100000;
    // done strobes once the item has passed the item and result registers, so a short settle is plenty
    localparam int SETTLE_CYCLES = 10;

    // one key event as it goes onto the ports, plus how the sender paces it
    typedef struct {
        action_t    act;
        logic [7:0] code;
        logic       link;
        logic [7:0] led;
        logic       match;
        int         idle_pct;  // chance in a hundred that the sender idles a cycle
        bit         drain;     // hold this item back until every report is back
    } key_event_t;

    // one report as the core shows it on done
    typedef struct {
        status_t    status;
        logic       sent;
        logic [7:0] mods;
        logic [7:0] keys [SHOWN_SLOTS];
        logic [7:0] leds;
    } report_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    action_t    action = ACT_PRESS;
    logic [7:0] keycode = 8'h00;
    logic       link_up = 1'b0;
    logic [7:0] led_byte = 8'h00;
    logic       report_match = 1'b0;

    logic       busy;
    logic       done;
    status_t    status;
    logic       report_sent;
    logic [7:0] modifiers;
    logic [7:0] key_a, key_b, key_c, key_d, key_e, key_f;
    logic [7:0] led_state;

    hid_keyboard_report_builder_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .keycode      (keycode),
        .link_up      (link_up),
        .led_byte     (led_byte),
        .report_match (report_match),
        .done         (done),
        .status       (status),
        .report_sent  (report_sent),
        .modifiers    (modifiers),
        .key_a        (key_a),
        .key_b        (key_b),
        .key_c        (key_c),
        .key_d        (key_d),
        .key_e        (key_e),
        .key_f        (key_f),
        .led_state    (led_state)
    );

    always #5 clk = ~clk;

    // shadow copy of the keyboard state, advanced in the order items are taken
    logic [7:0] mod_bits;
    logic [7:0] key_slot [KEY_SLOTS];
    logic [7:0] led_copy;

    key_event_t pending_events [$];
    report_t    expected_reports [$];
    key_event_t on_port;
    int         mismatches = 0;
    int         cycle_count = 0;

    // apply one key event to the shadow state and return the report it should give
    function automatic report_t update_report(key_event_t ev);
        report_t r;
        bit      is_mod;
        bit      held;
        bit      send;
        int      open_slot;
        is_mod    = (ev.code >= MOD_FIRST) && (ev.code <= MOD_LAST);
        held      = 1'b0;
        send      = 1'b0;
        open_slot = -1;
        r.status  = ST_OK;
        r.sent    = 1'b0;
        case (ev.act)
            ACT_PRESS:
            begin
                if (ev.code == NO_KEY)
                begin
                    r.status = ST_INVALID;
                end
                else if (is_mod)
                begin
                    // low three bits of 0xe0..0xe7 pick the modifier bit
                    mod_bits[ev.code[2:0]] = 1'b1;
                    send = 1'b1;
                end
                else
                begin
                    for (int i = 0; i < KEY_SLOTS; i++)
                    begin
                        if (key_slot[i] == ev.code)
                            held = 1'b1;
                        if (open_slot < 0 && key_slot[i] == NO_KEY)
                            open_slot = i;
                    end
                    // a key already held is a quiet no-op
                    if (!held)
                    begin
                        if (open_slot < 0)
                        begin
                            r.status = ST_FULL;
                        end
                        else
                        begin
                            key_slot[open_slot] = ev.code;
                            send = 1'b1;
                        end
                    end
                end
            end
            ACT_RELEASE:
            begin
                if (ev.code == NO_KEY)
                begin
                    r.status = ST_INVALID;
                end
                else
                begin
                    if (is_mod)
                    begin
                        mod_bits[ev.code[2:0]] = 1'b0;
                    end
                    else
                    begin
                        for (int i = 0; i < KEY_SLOTS; i++)
                        begin
                            if (key_slot[i] == ev.code)
                            begin
                                key_slot[i] = NO_KEY;
                                break;
                            end
                        end
                    end
                    // a release always reports, held or not
                    send = 1'b1;
                end
            end
            ACT_RELEASE_ALL:
            begin
                mod_bits = 8'h00;
                for (int i = 0; i < KEY_SLOTS; i++)
                    key_slot[i] = NO_KEY;
                send = 1'b1;
            end
            default:
            begin
                // host led report: only a matching report id updates the byte
                if (ev.match)
                    led_copy = ev.led;
            end
        endcase
        // link down still updates the state, only the send is lost
        if (send)
        begin
            r.status = ev.link ? ST_OK : ST_NOLINK;
            r.sent   = ev.link;
        end
        r.mods = mod_bits;
        for (int i = 0; i < SHOWN_SLOTS; i++)
            r.keys[i] = (i < KEY_SLOTS) ? key_slot[i] : NO_KEY;
        r.leds = led_copy;
        return r;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void add_event(action_t act, logic [7:0] code, logic link,
                                      logic [7:0] led, logic match, int idle_pct, bit drain);
        key_event_t ev;
        ev.act      = act;
        ev.code     = code;
        ev.link     = link;
        ev.led      = led;
        ev.match    = match;
        ev.idle_pct = idle_pct;
        ev.drain    = drain;
        pending_events.push_back(ev);
    endfunction

    // random event biased toward a small key pool so slots fill, collide and free up
    function automatic void add_random_event(int idle_pct, bit drain);
        int         pick;
        action_t    act;
        logic [7:0] code;
        pick = $urandom_range(99);
        if (pick < 45)
            act = ACT_PRESS;
        else if (pick < 80)
            act = ACT_RELEASE;
        else if (pick < 85)
            act = ACT_RELEASE_ALL;
        else
            act = ACT_HOST_LED;
        pick = $urandom_range(99);
        if (pick < 3)
            code = NO_KEY;
        else if (pick < 63)
            code = 8'h04 + 8'($urandom_range(11));
        else if (pick < 80)
            code = MOD_FIRST + 8'($urandom_range(7));
        else
            code = 8'($urandom);
        add_event(act, code, ($urandom_range(9) != 0), 8'($urandom), 1'($urandom),
                  idle_pct, drain);
    endfunction

    // sender: presents the head of the pending queue, holds it while busy,
    // and puts noise on the fields while start is low
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            // item taken at this edge: predict its report now
            if (start && !busy)
                expected_reports.push_back(update_report(on_port));
            if (start && busy)
            begin
                // hold the item until the core takes it
            end
            else if (pending_events.size() > 0
                     && (!pending_events[0].drain || expected_reports.size() == 0)
                     && $urandom_range(99) >= pending_events[0].idle_pct)
            begin
                on_port = pending_events.pop_front();
                start        <= 1'b1;
                action       <= on_port.act;
                keycode      <= on_port.code;
                link_up      <= on_port.link;
                led_byte     <= on_port.led;
                report_match <= on_port.match;
            end
            else
            begin
                start        <= 1'b0;
                action       <= action_t'($urandom_range(3));
                keycode      <= 8'($urandom);
                link_up      <= 1'($urandom);
                led_byte     <= 8'($urandom);
                report_match <= 1'($urandom);
            end
        end
    end

    // receiver: every done strobe must match the oldest predicted report
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_reports.size() == 0)
            begin
                $display("%0t ns: report with none expected, expected nothing, got status %0d",
                         $time, status);
                mismatches++;
            end
            else
            begin
                report_t    want;
                logic [7:0] seen_keys [SHOWN_SLOTS];
                want = expected_reports.pop_front();
                seen_keys = '{key_a, key_b, key_c, key_d, key_e, key_f};
                check_field("status", 8'(want.status), 8'(status));
                check_field("report_sent", 8'(want.sent), 8'(report_sent));
                check_field("modifiers", want.mods, modifiers);
                for (int i = 0; i < SHOWN_SLOTS; i++)
                    check_field($sformatf("key slot %0d", i), want.keys[i], seen_keys[i]);
                check_field("led_state", want.leds, led_state);
            end
        end
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // watchdog
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        mod_bits = 8'h00;
        for (int i = 0; i < KEY_SLOTS; i++)
            key_slot[i] = NO_KEY;
        led_copy = 8'h00;

        // directed: zero keycode on press and release
        add_event(ACT_PRESS, NO_KEY, 1'b1, 8'h00, 1'b0, 0, 1'b0);
        add_event(ACT_RELEASE, NO_KEY, 1'b1, 8'h00, 1'b0, 0, 1'b0);
        // both ends of the modifier range
        add_event(ACT_PRESS, MOD_FIRST, 1'b1, 8'h00, 1'b0, 0, 1'b0);
        add_event(ACT_PRESS, MOD_LAST, 1'b1, 8'h00, 1'b0, 0, 1'b0);
        // fill every slot, the last one with the link down
        add_event(ACT_PRESS, 8'h04, 1'b1, 8'h00, 1'b0, 0, 1'b0);
        add_event(ACT_PRESS, 8'h05, 1'b1, 8'h00, 1'b0, 0, 1'b0);
        add_event(ACT_PRESS, 8'h06, 1'b1, 8'h00, 1'b0, 0, 1'b0);
        add_event(ACT_PRESS, 8'h07, 1'b1, 8'h00, 1'b0, 0, 1'b0);
        add_event(ACT_PRESS, 8'h08, 1'b1, 8'h00, 1'b0, 0, 1'b0);
        add_event(ACT_PRESS, 8'h09, 1'b0, 8'h00, 1'b0, 0, 1'b0);
        // no free slot, then a key already held
        add_event(ACT_PRESS, 8'h0A, 1'b1, 8'h00, 1'b0, 0, 1'b0);
        add_event(ACT_PRESS, 8'h04, 1'b1, 8'h00, 1'b0, 0, 1'b0);
        // release of a held key and of one not held
        add_event(ACT_RELEASE, 8'h05, 1'b1, 8'h00, 1'b0, 0, 1'b0);
        add_event(ACT_RELEASE, 8'h33, 1'b1, 8'h00, 1'b0, 0, 1'b0);
        // codes above the modifier range are plain keys
        add_event(ACT_PRESS, 8'hE8, 1'b1, 8'h00, 1'b0, 0, 1'b0);
        add_event(ACT_PRESS, 8'hFF, 1'b1, 8'h00, 1'b0, 0, 1'b0);
        add_event(ACT_RELEASE, MOD_FIRST, 1'b0, 8'h00, 1'b0, 0, 1'b0);
        // host led reports, matching and not
        add_event(ACT_HOST_LED, 8'h00, 1'b1, 8'hFF, 1'b1, 0, 1'b0);
        add_event(ACT_HOST_LED, 8'h00, 1'b1, 8'h55, 1'b0, 0, 1'b0);
        add_event(ACT_HOST_LED, 8'hFF, 1'b0, 8'hA5, 1'b1, 0, 1'b0);
        // release-all with the link down and up
        add_event(ACT_RELEASE_ALL, 8'h00, 1'b0, 8'h00, 1'b0, 0, 1'b0);
        add_event(ACT_RELEASE_ALL, 8'hFF, 1'b1, 8'h00, 1'b0, 0, 1'b0);
        add_event(ACT_RELEASE, 8'hFF, 1'b1, 8'h00, 1'b0, 0, 1'b0);
        add_event(ACT_PRESS, 8'hFF, 1'b1, 8'h00, 1'b0, 0, 1'b0);
        add_event(ACT_HOST_LED, 8'h00, 1'b1, 8'h00, 1'b1, 0, 1'b0);

        // random phases: no idling, heavy idling, none again, light idling;
        // the first item of each phase waits for the pipe to run dry
        for (int p = 0; p < 4; p++)
        begin
            int idle_pct;
            idle_pct = (p == 1) ? 57 : (p == 3) ? 27 : 0;
            for (int n = 0; n < 400; n++)
                add_random_event(idle_pct, n == 0);
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // wait for the sender to run out and every report to come back
        while (pending_events.size() != 0 || start || expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_reports.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
